// ----- design/b64_pkg.sv -----
// Shared types, result codes and alphabet decode for the Base64 stream decoder.
package b64_pkg;

  localparam int FIFO_DEPTH_DEF = 4;
  localparam int MAX_RES        = 4;

  localparam logic [2:0] KIND_DATA       = 3'd0;
  localparam logic [2:0] KIND_PAD        = 3'd1;
  localparam logic [2:0] KIND_INVALID    = 3'd2;
  localparam logic [2:0] KIND_INCOMPLETE = 3'd3;
  localparam logic [2:0] KIND_END        = 3'd4;

  localparam logic [1:0] PAD_NONE  = 2'd0;
  localparam logic [1:0] PAD_THIRD = 2'd1;
  localparam logic [1:0] PAD_FOURTH = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PAD   = 8'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] kind;
  } result_t;

  // Results caused by one accepted character, oldest in slot 0.
  typedef struct packed {
    logic [2:0]              cnt;
    logic                    eom;
    result_t [MAX_RES-1:0]   res;
  } bundle_t;

  // Returns {valid, value} for one alphabet character.
  function automatic logic [6:0] sym_decode(input logic [7:0] c);
    logic [7:0] tmp;
    logic [6:0] r;
    tmp = 8'd0;
    r   = 7'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      tmp = c - 8'h41;
      r   = {1'b1, tmp[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      tmp = c - 8'h47;
      r   = {1'b1, tmp[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      tmp = c + 8'h04;
      r   = {1'b1, tmp[5:0]};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// ----- design/b64_front.sv -----
// Front end: accepts characters, tracks the quad state and builds result bundles.
module b64_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_char_code,
  input  logic             in_end_of_message,
  input  logic             q_full,
  output logic             q_wr,
  output b64_pkg::bundle_t q_wdata
);
  import b64_pkg::*;

  logic [17:0] qb_r, qb_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  pm_r, pm_nxt;

  logic        accept;
  logic        skip;
  logic [6:0]  dec;
  logic [5:0]  v;
  logic [23:0] shifted;
  logic [1:0]  cnt_new;
  logic [1:0]  pm_new;
  bundle_t     b;
  logic [2:0]  n;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign dec    = sym_decode(in_char_code);

  always_comb begin
    skip    = (in_char_code == CH_SPACE) || (in_char_code == CH_TAB) ||
              (in_char_code == CH_LF) || (in_char_code == CH_CR);
    v       = 6'd0;
    pm_new  = pm_r;
    cnt_new = cnt_r;
    shifted = {qb_r, 6'd0};
    b       = '0;
    n       = 3'd0;
    if (!skip) begin
      if (in_char_code == CH_PAD) begin
        if (pm_r == PAD_NONE) begin
          if (cnt_r == 2'd2) begin
            pm_new = PAD_THIRD;
          end else if (cnt_r == 2'd3) begin
            pm_new = PAD_FOURTH;
          end else begin
            b.res[n[1:0]] = '{data_byte: 8'd0, kind: KIND_PAD};
            n = n + 3'd1;
          end
        end
      end else if (dec[6]) begin
        v = dec[5:0];
      end else begin
        b.res[n[1:0]] = '{data_byte: 8'd0, kind: KIND_INVALID};
        n = n + 3'd1;
      end
      shifted = {qb_r, v};
      cnt_new = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        b.res[n[1:0]] = '{data_byte: shifted[23:16], kind: KIND_DATA};
        n = n + 3'd1;
        if (pm_new != PAD_THIRD) begin
          b.res[n[1:0]] = '{data_byte: shifted[15:8], kind: KIND_DATA};
          n = n + 3'd1;
        end
        if (pm_new == PAD_NONE) begin
          b.res[n[1:0]] = '{data_byte: shifted[7:0], kind: KIND_DATA};
          n = n + 3'd1;
        end
      end
    end
    if (in_end_of_message) begin
      if (cnt_new != 2'd0) begin
        b.res[n[1:0]] = '{data_byte: 8'd0, kind: KIND_INCOMPLETE};
        n = n + 3'd1;
      end else if (n == 3'd0) begin
        b.res[n[1:0]] = '{data_byte: 8'd0, kind: KIND_END};
        n = n + 3'd1;
      end
    end
    b.cnt = n;
    b.eom = in_end_of_message;
  end

  always_comb begin
    qb_nxt  = qb_r;
    cnt_nxt = cnt_r;
    pm_nxt  = pm_r;
    if (accept) begin
      if (in_end_of_message) begin
        qb_nxt  = '0;
        cnt_nxt = 2'd0;
        pm_nxt  = PAD_NONE;
      end else begin
        if (!skip) qb_nxt = (cnt_r == 2'd3) ? 18'd0 : shifted[17:0];
        cnt_nxt = cnt_new;
        pm_nxt  = pm_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qb_r  <= '0;
      cnt_r <= 2'd0;
      pm_r  <= PAD_NONE;
    end else begin
      qb_r  <= qb_nxt;
      cnt_r <= cnt_nxt;
      pm_r  <= pm_nxt;
    end
  end

  assign q_wr    = accept && (b.cnt != 3'd0);
  assign q_wdata = b;

endmodule

// ----- design/b64_fifo.sv -----
// Small bundle queue between the front end and the result sequencer.
module b64_fifo #(
  parameter int DEPTH = b64_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  b64_pkg::bundle_t wdata,
  output logic             q_full,
  input  logic             rd,
  output b64_pkg::bundle_t rdata,
  output logic             q_empty
);
  import b64_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t        mem [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    if (do_rd) rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    if (do_wr && !do_rd) cnt_nxt = cnt_r + CW'(1);
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- design/b64_back.sv -----
// Back end: holds one bundle and hands out its results one transaction at a time.
module b64_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  b64_pkg::bundle_t q_rdata,
  output logic             q_rd,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_data_byte,
  output logic [2:0]       out_kind,
  output logic             out_last
);
  import b64_pkg::*;

  bundle_t    bun_r, bun_nxt;
  logic       vld_r, vld_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       done;
  logic       take;

  assign done  = ({1'b0, idx_r} == (bun_r.cnt - 3'd1));
  assign take  = vld_r && pop;
  assign q_rd  = (!vld_r || (take && done)) && !q_empty;
  assign empty = !vld_r;

  assign out_data_byte = bun_r.res[idx_r].data_byte;
  assign out_kind      = bun_r.res[idx_r].kind;
  assign out_last      = bun_r.eom && done;

  always_comb begin
    bun_nxt = bun_r;
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (take && !done) begin
      idx_nxt = idx_r + 2'd1;
    end else if (!vld_r || take) begin
      idx_nxt = 2'd0;
      vld_nxt = !q_empty;
      if (!q_empty) bun_nxt = q_rdata;
    end
  end

  always_ff @(posedge clk) begin
    bun_r <= bun_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

// ----- design/base64_stream_decoder.sv -----
// Top level of the Base64 stream decoder: front end, bundle queue, result sequencer.
//
//  channel   handshake        payload
//  input     push / full      in_char_code[7:0], in_end_of_message
//  result    empty / pop      out_data_byte[7:0], out_kind[2:0], out_last
//
// One character is accepted per cycle while the bundle queue has room.
// Each character yields zero to four results; the sequencer emits one per cycle while pop is asserted,
// so characters with several results hold off the input once the bundle queue fills.
// First result reaches the outputs through the bundle queue and the sequencer's bundle register.
// Synchronous active-low reset clears quad state and queue and marks the output empty.
module base64_stream_decoder #(
  parameter int FIFO_DEPTH = b64_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_kind,
  output logic       out_last
);
  import b64_pkg::*;

  logic    q_full, q_empty, q_wr, q_rd;
  bundle_t q_wdata, q_rdata;

  b64_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_char_code      (in_char_code),
    .in_end_of_message (in_end_of_message),
    .q_full            (q_full),
    .q_wr              (q_wr),
    .q_wdata           (q_wdata)
  );

  b64_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .rdata   (q_rdata),
    .q_empty (q_empty)
  );

  b64_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_rdata       (q_rdata),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .out_data_byte (out_data_byte),
    .out_kind      (out_kind),
    .out_last      (out_last)
  );

endmodule

// ----- design/b64_checker.sv -----
// Port-level checks for the Base64 stream decoder and their bind.
module b64_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_data_byte,
  input logic [2:0] out_kind,
  input logic       out_last
);
  import b64_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("outputs not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_kind) && $stable(out_data_byte)
      && $stable(out_last))
    else $error("pending result changed before pop");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_kind != KIND_DATA |-> out_data_byte == 8'd0)
    else $error("nonzero byte on status result");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_kind == KIND_INCOMPLETE || out_kind == KIND_END) |-> out_last)
    else $error("end result without last");

endmodule

bind base64_stream_decoder b64_checker u_b64_checker (.*);
